>>> hdl/ald_pkg.sv
// shared constants, types and helpers of the antialiased line drawer
package ald_pkg;

   localparam int MAX_WIDTH       = 256;
   localparam int MAX_HEIGHT      = 256;
   localparam int COORD_FRAC_BITS = 8;
   localparam int Q_FRAC          = 16;
   localparam int Q_HALF          = 1 << (Q_FRAC - 1);
   localparam int Q_ONE           = 1 << Q_FRAC;

   localparam int CRD_W     = 24;
   localparam int COL_W     = 8;
   localparam int RGB_W     = 3 * COL_W;
   localparam int ALPHA_W   = 9;
   localparam int FUNC_W    = 2;
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CFG_RESET = 256;

   localparam int X_W    = $clog2(MAX_WIDTH);
   localparam int Y_W    = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = X_W + Y_W;
   localparam int DIM_W  = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1;

   localparam int NUM_W  = 27;
   localparam int PROD_W = 2 * NUM_W;
   localparam int POS_W  = 28;
   localparam int DIV_W  = 58;
   localparam int DIVR_W = 26;
   localparam int WGT_W  = 26;
   localparam int PIX_W  = 14;
   localparam int CHP_W  = COL_W + 1 + WGT_W + 1;
   localparam int CLIP_SHIFT  = Q_FRAC - COORD_FRAC_BITS;
   localparam int FULL_ALPHA  = 256;
   localparam int BLEND_SHIFT = 24;
   localparam int FULL_WEIGHT = 1 << BLEND_SHIFT;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 24;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [CRD_W-1:0] sx;
      logic signed [CRD_W-1:0] sy;
      logic signed [CRD_W-1:0] ex;
      logic signed [CRD_W-1:0] ey;
      logic [COL_W-1:0]        red;
      logic [COL_W-1:0]        green;
      logic [COL_W-1:0]        blue;
      logic [ALPHA_W-1:0]      alpha;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0] used_w;
      logic [DIM_W-1:0] used_h;
   } cfg_type;

   typedef struct packed {
      logic init_busy;
   } status_type;

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y);
      pix_addr = ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
   endfunction

endpackage

>>> hdl/ald_div.sv
// iterative floor divider, one quotient bit per cycle
module ald_div import ald_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     div_start,
   input  logic signed [DIV_W-1:0]  div_dividend,
   input  logic [DIVR_W-1:0]        div_divisor,
   output logic                     div_done,
   output logic signed [DIV_W-1:0]  div_quot
);

   localparam int CNT_W = $clog2(DIV_W);

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIX} dv_state_type;

   dv_state_type            state_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [DIV_W-1:0]        mag_ff;
   logic [DIVR_W-1:0]       rem_ff;
   logic [DIVR_W-1:0]       dsr_ff;
   logic                    neg_ff;
   logic                    done_ff;
   logic signed [DIV_W-1:0] quot_ff;

   logic [DIVR_W:0] rem_sh;
   logic [DIVR_W:0] rem_diff;
   logic            rem_ge;

   assign rem_sh   = {rem_ff, mag_ff[DIV_W-1]};
   assign rem_diff = rem_sh - {1'b0, dsr_ff};
   assign rem_ge   = rem_sh >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            DV_IDLE: begin
               if (div_start) begin
                  neg_ff   <= div_dividend[DIV_W-1];
                  mag_ff   <= div_dividend[DIV_W-1] ? DIV_W'(-div_dividend) : div_dividend;
                  dsr_ff   <= div_divisor;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               mag_ff <= {mag_ff[DIV_W-2:0], rem_ge};
               rem_ff <= rem_ge ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_W - 1)) state_ff <= DV_FIX;
            end
            DV_FIX: begin
               if (!neg_ff) quot_ff <= mag_ff;
               else if (rem_ff != '0) quot_ff <= ~mag_ff;
               else quot_ff <= -mag_ff;
               done_ff  <= 1'b1;
               state_ff <= DV_IDLE;
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign div_done = done_ff;
   assign div_quot = quot_ff;

endmodule

>>> hdl/ald_front.sv
// command intake: unpacks beats, clamps alpha and queues them for the drawing engine
module ald_front import ald_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   input  status_type            status,
   output logic                  q_valid,
   output cmd_type               q_cmd,
   input  logic                  q_pop
);

   cmd_type    fifo_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;

   cmd_type cmd_in;
   logic    push;
   logic    pop;

   always_comb begin
      cmd_in.func  = req_tuser;
      cmd_in.sx    = req_tdata[23:0];
      cmd_in.sy    = req_tdata[47:24];
      cmd_in.ex    = req_tdata[71:48];
      cmd_in.ey    = req_tdata[95:72];
      cmd_in.red   = req_tdata[103:96];
      cmd_in.green = req_tdata[111:104];
      cmd_in.blue  = req_tdata[119:112];
      if (int'(req_tdata[128:120]) > FULL_ALPHA) cmd_in.alpha = ALPHA_W'(FULL_ALPHA);
      else cmd_in.alpha = req_tdata[128:120];
   end

   assign req_tready = (cnt_ff != 2'd2) && !status.init_busy;
   assign push       = req_tvalid && req_tready;
   assign q_valid    = cnt_ff != 2'd0;
   assign pop        = q_pop && q_valid;
   assign q_cmd      = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= cmd_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

endmodule

>>> hdl/ald_back.sv
// drawing engine: framebuffer, clear sweep, pixel read, clipping and wu line walk
module ald_back import ald_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   output status_type            status,
   input  logic                  q_valid,
   input  cmd_type               q_cmd,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   typedef enum logic [4:0] {
      S_FILL, S_IDLE, S_READ, S_READ_WAIT, S_READ_DATA, S_LINE, S_SIDE, S_MUL_A,
      S_MUL_B, S_TEST, S_CP_MUL, S_CP_DIV, S_CP_WAIT, S_ORIENT, S_SWAP, S_GRAD,
      S_GRAD_WAIT, S_POS_MUL, S_POS_ADD, S_WEIGHT, S_CHECK, S_BL_MUL, S_BL_WRITE,
      S_ADV, S_RESULT
   } state_type;

   state_type state_ff;
   cmd_type   cmd_ff;

   logic signed [NUM_W-1:0] dx_ff, dy_ff, n0_ff, d0_ff, n1_ff, d1_ff, num_ff, den_ff;
   logic [1:0]              side_ff;
   logic                    phase_ff;
   logic                    neg_ff;
   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic [1:0]              cp_idx_ff;
   logic signed [POS_W-1:0] pt_ff [4];
   logic                    ymaj_ff;
   logic signed [POS_W-1:0] ma0_ff, mi0_ff, ma1_ff, mi1_ff;
   logic [DIM_W-1:0]        s_ff, e_ff, k_ff;
   logic signed [POS_W-1:0] grad_ff, pos_ff;
   logic                    half_ff;
   logic [WGT_W-1:0]        wgt_ff;
   logic signed [PIX_W-1:0] px_ff, py_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic signed [CHP_W-1:0] chp_ff [3];
   logic [X_W-1:0]          fill_x_ff, lim_x_ff;
   logic [Y_W-1:0]          fill_y_ff, lim_y_ff;
   logic [RGB_W-1:0]        fill_col_ff;
   logic                    init_ff;
   logic                    rd_ok_ff;
   logic [RGB_W-1:0]        res_col_ff;
   logic                    res_rej_ff;
   logic                    rsp_valid_ff;
   logic [RGB_W-1:0]        rsp_col_ff;
   logic                    rsp_rej_ff;
   logic [RGB_W-1:0]        rd_data_ff;
   logic [RGB_W-1:0]        frame_mem [MAX_WIDTH * MAX_HEIGHT];

   logic signed [NUM_W-1:0]  wl, hl, sx_w, sy_w, side_p, side_q;
   logic signed [NUM_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic                     sel_hi, test_gt;
   logic signed [NUM_W-1:0]  cp_n, cp_d, cp_delta, cp_o;
   logic signed [DIV_W-1:0]  cp_sum;
   logic                     div_start, div_done;
   logic signed [DIV_W-1:0]  div_dividend, div_quot;
   logic [DIVR_W-1:0]        div_divisor;
   logic signed [POS_W-1:0]  dxc, dyc, adx, ady, dma, dmi, ma0_half, ma1_half;
   logic [Q_FRAC:0]          cov;
   logic signed [PIX_W-1:0]  minor, kpix, wide_w, wide_h;
   logic                     pix_ok, pix_full;
   logic signed [CRD_W-COORD_FRAC_BITS-1:0] rd_col, rd_row;
   logic [RGB_W-1:0]         line_col, blended;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [RGB_W-1:0]         mem_wdata;

   assign wl = NUM_W'(cfg.used_w - DIM_W'(1)) <<< COORD_FRAC_BITS;
   assign hl = NUM_W'(cfg.used_h - DIM_W'(1)) <<< COORD_FRAC_BITS;
   assign sx_w = NUM_W'(cmd_ff.sx);
   assign sy_w = NUM_W'(cmd_ff.sy);
   assign wide_w = PIX_W'(cfg.used_w);
   assign wide_h = PIX_W'(cfg.used_h);
   assign line_col = {cmd_ff.red, cmd_ff.green, cmd_ff.blue};

   // clip side selection
   always_comb begin
      case (side_ff)
         2'd0: begin side_p = -dx_ff; side_q = sx_w; end
         2'd1: begin side_p = dx_ff;  side_q = wl - sx_w; end
         2'd2: begin side_p = -dy_ff; side_q = sy_w; end
         default: begin side_p = dy_ff; side_q = hl - sy_w; end
      endcase
   end

   assign sel_hi  = neg_ff ^ phase_ff;
   assign test_gt = neg_ff ? (prod_a_ff > prod_b_ff) : (prod_a_ff < prod_b_ff);

   assign cp_n     = cp_idx_ff[1] ? n1_ff : n0_ff;
   assign cp_d     = cp_idx_ff[1] ? d1_ff : d0_ff;
   assign cp_delta = cp_idx_ff[0] ? dy_ff : dx_ff;
   assign cp_o     = cp_idx_ff[0] ? sy_w : sx_w;
   assign cp_sum   = (DIV_W'(cp_o) <<< Q_FRAC - COORD_FRAC_BITS) + div_quot;

   assign dxc = pt_ff[2] - pt_ff[0];
   assign dyc = pt_ff[3] - pt_ff[1];
   assign adx = dxc[POS_W-1] ? -dxc : dxc;
   assign ady = dyc[POS_W-1] ? -dyc : dyc;
   assign dma = ma1_ff - ma0_ff;
   assign dmi = mi1_ff - mi0_ff;
   assign ma0_half = ma0_ff + POS_W'(Q_HALF);
   assign ma1_half = ma1_ff + POS_W'(Q_HALF);

   assign cov   = half_ff ? {1'b0, pos_ff[Q_FRAC-1:0]}
                          : (Q_FRAC + 1)'(Q_ONE) - {1'b0, pos_ff[Q_FRAC-1:0]};
   assign minor = PIX_W'($signed(pos_ff[POS_W-1:Q_FRAC])) + PIX_W'(half_ff);
   assign kpix  = PIX_W'(k_ff);

   assign pix_ok   = (px_ff >= 0) && (px_ff < wide_w) && (py_ff >= 0) && (py_ff < wide_h)
                     && (wgt_ff != '0);
   assign pix_full = wgt_ff >= WGT_W'(FULL_WEIGHT);

   assign rd_col = cmd_ff.sx[CRD_W-1:COORD_FRAC_BITS];
   assign rd_row = cmd_ff.sy[CRD_W-1:COORD_FRAC_BITS];

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_A: begin
            mul_a = num_ff;
            mul_b = sel_hi ? d1_ff : d0_ff;
         end
         S_MUL_B: begin
            mul_a = sel_hi ? n1_ff : n0_ff;
            mul_b = den_ff;
         end
         S_CP_MUL: begin
            mul_a = cp_n;
            mul_b = cp_delta;
         end
         S_POS_MUL: begin
            mul_a = NUM_W'(grad_ff);
            mul_b = NUM_W'(POS_W'({s_ff, {Q_FRAC{1'b0}}}) - ma0_ff);
         end
         S_WEIGHT: begin
            mul_a = NUM_W'(cmd_ff.alpha);
            mul_b = NUM_W'(cov);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // divider operands
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      if (state_ff == S_CP_DIV) begin
         div_start    = 1'b1;
         div_dividend = DIV_W'(prod_a_ff) <<< CLIP_SHIFT;
         div_divisor  = cp_d[DIVR_W-1:0];
      end else if (state_ff == S_GRAD) begin
         div_start    = dma != '0;
         div_dividend = DIV_W'(dmi) <<< Q_FRAC;
         div_divisor  = dma[DIVR_W-1:0];
      end
   end

   ald_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quot     (div_quot)
   );

   // blend result
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         blended[RGB_W-COL_W*(i+1) +: COL_W] = rd_data_ff[RGB_W-COL_W*(i+1) +: COL_W]
                                            + chp_ff[i][BLEND_SHIFT +: COL_W];
      end
   end

   // framebuffer write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = blended;
      case (state_ff)
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = pix_addr(fill_x_ff, fill_y_ff);
            mem_wdata = fill_col_ff;
         end
         S_CHECK: begin
            mem_we    = pix_ok && pix_full;
            mem_wdata = line_col;
         end
         S_BL_WRITE: mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= frame_mem[addr_ff];
   end

   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         init_ff      <= 1'b1;
         fill_x_ff    <= '0;
         fill_y_ff    <= '0;
         lim_x_ff     <= X_W'(MAX_WIDTH - 1);
         lim_y_ff     <= Y_W'(MAX_HEIGHT - 1);
         fill_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_FILL: begin
               if (fill_x_ff == lim_x_ff) begin
                  fill_x_ff <= '0;
                  fill_y_ff <= fill_y_ff + 1'b1;
                  if (fill_y_ff == lim_y_ff) begin
                     init_ff  <= 1'b0;
                     state_ff <= init_ff ? S_IDLE : S_RESULT;
                  end
               end else begin
                  fill_x_ff <= fill_x_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff     <= q_cmd;
                  res_col_ff <= '0;
                  res_rej_ff <= 1'b0;
                  case (q_cmd.func)
                     FUNC_CLEAR: begin
                        fill_col_ff <= {q_cmd.red, q_cmd.green, q_cmd.blue};
                        fill_x_ff   <= '0;
                        fill_y_ff   <= '0;
                        lim_x_ff    <= X_W'(cfg.used_w - DIM_W'(1));
                        lim_y_ff    <= Y_W'(cfg.used_h - DIM_W'(1));
                        state_ff    <= S_FILL;
                     end
                     FUNC_LINE: state_ff <= S_LINE;
                     FUNC_READ: state_ff <= S_READ;
                     default:   state_ff <= S_RESULT;
                  endcase
               end
            end
            S_READ: begin
               rd_ok_ff <= (rd_col >= 0) && (rd_row >= 0)
                           && (rd_col < $signed((CRD_W-COORD_FRAC_BITS)'(cfg.used_w)))
                           && (rd_row < $signed((CRD_W-COORD_FRAC_BITS)'(cfg.used_h)));
               addr_ff  <= pix_addr(rd_col[X_W-1:0], rd_row[Y_W-1:0]);
               state_ff <= S_READ_WAIT;
            end
            S_READ_WAIT: state_ff <= S_READ_DATA;
            S_READ_DATA: begin
               res_col_ff <= rd_ok_ff ? rd_data_ff : '0;
               state_ff   <= S_RESULT;
            end
            S_LINE: begin
               dx_ff    <= NUM_W'(cmd_ff.ex) - sx_w;
               dy_ff    <= NUM_W'(cmd_ff.ey) - sy_w;
               n0_ff    <= NUM_W'(0);
               d0_ff    <= NUM_W'(1);
               n1_ff    <= NUM_W'(1);
               d1_ff    <= NUM_W'(1);
               side_ff  <= 2'd0;
               state_ff <= S_SIDE;
            end
            S_SIDE: begin
               if (side_p == '0) begin
                  if (side_q < 0) begin
                     res_rej_ff <= 1'b1;
                     state_ff   <= S_RESULT;
                  end else if (side_ff == 2'd3) begin
                     cp_idx_ff <= 2'd0;
                     state_ff  <= S_CP_MUL;
                  end else begin
                     side_ff <= side_ff + 2'd1;
                  end
               end else begin
                  neg_ff   <= side_p < 0;
                  num_ff   <= (side_p < 0) ? -side_q : side_q;
                  den_ff   <= (side_p < 0) ? -side_p : side_p;
                  phase_ff <= 1'b0;
                  state_ff <= S_MUL_A;
               end
            end
            S_MUL_A: begin
               prod_a_ff <= mul_p;
               state_ff  <= S_MUL_B;
            end
            S_MUL_B: begin
               prod_b_ff <= mul_p;
               state_ff  <= S_TEST;
            end
            S_TEST: begin
               if (!phase_ff) begin
                  if (test_gt) begin
                     res_rej_ff <= 1'b1;
                     state_ff   <= S_RESULT;
                  end else begin
                     phase_ff <= 1'b1;
                     state_ff <= S_MUL_A;
                  end
               end else begin
                  if (test_gt) begin
                     if (neg_ff) begin
                        n0_ff <= num_ff;
                        d0_ff <= den_ff;
                     end else begin
                        n1_ff <= num_ff;
                        d1_ff <= den_ff;
                     end
                  end
                  if (side_ff == 2'd3) begin
                     cp_idx_ff <= 2'd0;
                     state_ff  <= S_CP_MUL;
                  end else begin
                     side_ff  <= side_ff + 2'd1;
                     state_ff <= S_SIDE;
                  end
               end
            end
            S_CP_MUL: begin
               prod_a_ff <= mul_p;
               state_ff  <= S_CP_DIV;
            end
            S_CP_DIV: state_ff <= S_CP_WAIT;
            S_CP_WAIT: begin
               if (div_done) begin
                  pt_ff[cp_idx_ff] <= POS_W'(cp_sum);
                  cp_idx_ff        <= cp_idx_ff + 2'd1;
                  state_ff         <= (cp_idx_ff == 2'd3) ? S_ORIENT : S_CP_MUL;
               end
            end
            S_ORIENT: begin
               ymaj_ff  <= adx < ady;
               ma0_ff   <= (adx < ady) ? pt_ff[1] : pt_ff[0];
               mi0_ff   <= (adx < ady) ? pt_ff[0] : pt_ff[1];
               ma1_ff   <= (adx < ady) ? pt_ff[3] : pt_ff[2];
               mi1_ff   <= (adx < ady) ? pt_ff[2] : pt_ff[3];
               state_ff <= S_SWAP;
            end
            S_SWAP: begin
               if (ma0_ff > ma1_ff) begin
                  ma0_ff <= ma1_ff;
                  ma1_ff <= ma0_ff;
                  mi0_ff <= mi1_ff;
                  mi1_ff <= mi0_ff;
               end
               state_ff <= S_GRAD;
            end
            S_GRAD: begin
               s_ff <= ma0_half[Q_FRAC +: DIM_W];
               e_ff <= ma1_half[Q_FRAC +: DIM_W];
               if (dma == '0) begin
                  grad_ff  <= '0;
                  state_ff <= S_POS_MUL;
               end else begin
                  state_ff <= S_GRAD_WAIT;
               end
            end
            S_GRAD_WAIT: begin
               if (div_done) begin
                  grad_ff  <= POS_W'(div_quot);
                  state_ff <= S_POS_MUL;
               end
            end
            S_POS_MUL: begin
               prod_a_ff <= mul_p;
               state_ff  <= S_POS_ADD;
            end
            S_POS_ADD: begin
               pos_ff   <= mi0_ff + POS_W'(prod_a_ff >>> Q_FRAC);
               k_ff     <= s_ff;
               half_ff  <= 1'b0;
               state_ff <= S_WEIGHT;
            end
            S_WEIGHT: begin
               wgt_ff   <= mul_p[WGT_W-1:0];
               px_ff    <= ymaj_ff ? minor : kpix;
               py_ff    <= ymaj_ff ? kpix : minor;
               addr_ff  <= ymaj_ff ? pix_addr(minor[X_W-1:0], k_ff[Y_W-1:0])
                                   : pix_addr(k_ff[X_W-1:0], minor[Y_W-1:0]);
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (pix_ok && !pix_full) state_ff <= S_BL_MUL;
               else state_ff <= S_ADV;
            end
            S_BL_MUL: begin
               for (int i = 0; i < 3; i++) begin
                  chp_ff[i] <= ($signed({1'b0, line_col[RGB_W-COL_W*(i+1) +: COL_W]})
                               - $signed({1'b0, rd_data_ff[RGB_W-COL_W*(i+1) +: COL_W]}))
                               * $signed({1'b0, wgt_ff});
               end
               state_ff <= S_BL_WRITE;
            end
            S_BL_WRITE: state_ff <= S_ADV;
            S_ADV: begin
               if (!half_ff) begin
                  half_ff  <= 1'b1;
                  state_ff <= S_WEIGHT;
               end else begin
                  half_ff <= 1'b0;
                  if (k_ff == e_ff) begin
                     state_ff <= S_RESULT;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     pos_ff   <= pos_ff + grad_ff;
                     state_ff <= S_WEIGHT;
                  end
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_col_ff   <= res_col_ff;
                  rsp_rej_ff   <= res_rej_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign status.init_busy = init_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_col_ff;
   assign rsp_tuser  = rsp_rej_ff;

endmodule

>>> hdl/antialiased_line_drawer.sv
// antialiased line drawer top level: configuration registers and the two halves
//
// Commands arrive as beats on the req_ channel (tuser selects clear, line or
// read) and each one returns exactly one beat on the rsp_ channel. The
// csr_ channel sets the frame width (index 0) and height (index 1); it is
// always ready and should only be written while no command is in flight.
// An intake queue of two commands sits ahead of the drawing engine, so new
// beats are taken while the engine works or while a response waits.
// After reset the framebuffer is swept to black, one pixel a cycle, over the
// whole 256 by 256 framebuffer; req_tready stays low for that time.
// Work per command: a clear sweeps width * height pixels; a read looks up one
// pixel; a line runs the clipping, four clip-point divisions and a gradient
// division, then steps along the major axis, paced by the single framebuffer
// port doing one read-modify-write per partly covered pixel.
// A response is held in an output register until rsp_tready; while it waits
// the engine stalls at its end and the intake queue keeps filling.
module antialiased_line_drawer import ald_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // alpha[128:120] blue[119:112] green[111:104] red[103:96]
   // end_y[95:72] end_x[71:48] start_y[47:24] start_x[23:0], rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_colour[23:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // line_rejected[0]
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   cfg_type          cfg;
   status_type       status;
   logic             q_valid;
   cmd_type          q_cmd;
   logic             q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(CFG_RESET);
         height_ff <= CFG_W'(CFG_RESET);
      end else if (csr_valid) begin
         if (csr_index == CSR_WIDTH) width_ff <= csr_data;
         if (csr_index == CSR_HEIGHT) height_ff <= csr_data;
      end
   end

   // sizes in use, limited to the framebuffer, with zero taken as one
   always_comb begin
      if (width_ff == '0) cfg.used_w = DIM_W'(1);
      else if (int'(width_ff) > MAX_WIDTH) cfg.used_w = DIM_W'(MAX_WIDTH);
      else cfg.used_w = DIM_W'(width_ff);
      if (height_ff == '0) cfg.used_h = DIM_W'(1);
      else if (int'(height_ff) > MAX_HEIGHT) cfg.used_h = DIM_W'(MAX_HEIGHT);
      else cfg.used_h = DIM_W'(height_ff);
   end

   ald_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   ald_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .status     (status),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> verif/antialiased_line_drawer_tb.sv
// self-checking testbench of the antialiased line drawer: frame model, scoreboard and stimulus
`timescale 1ns / 100ps

module antialiased_line_drawer_tb;
   import ald_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   typedef struct {
      logic [RGB_W-1:0] colour;
      logic             rejected;
   } pixel_reply_type;

   class frame_scoreboard;
      logic [RGB_W-1:0] frame[MAX_WIDTH*MAX_HEIGHT];
      longint           width_reg;
      longint           height_reg;
      pixel_reply_type  replies[$];
      int               errors;
      int               checked;
      int               lines;
      int               rejects;

      function new();
         foreach (frame[i]) frame[i] = '0;
         width_reg  = CFG_RESET;
         height_reg = CFG_RESET;
         errors     = 0;
         checked    = 0;
         lines      = 0;
         rejects    = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_WIDTH) width_reg = val;
         else if (idx == CSR_HEIGHT) height_reg = val;
      endfunction

      function longint used_w();
         return (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      endfunction

      function longint used_h();
         return (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      endfunction

      function longint fdiv(longint a, longint b);
         longint q;
         q = a / b;
         if (a % b < 0) q--;
         return q;
      endfunction

      function void blend(longint x, longint y, logic [COL_W-1:0] c[3], longint wgt);
         logic [RGB_W-1:0] d;
         logic [COL_W-1:0] o[3];
         longint           dc;
         if (x < 0 || y < 0 || x >= used_w() || y >= used_h() || wgt <= 0) return;
         if (wgt >= FULL_WEIGHT) begin
            frame[y*MAX_WIDTH+x] = {c[0], c[1], c[2]};
            return;
         end
         d = frame[y*MAX_WIDTH+x];
         for (int i = 0; i < 3; i++) begin
            dc   = (d >> (16 - 8*i)) & 8'hff;
            o[i] = COL_W'(dc + fdiv((longint'(c[i]) - dc) * wgt, FULL_WEIGHT));
         end
         frame[y*MAX_WIDTH+x] = {o[0], o[1], o[2]};
      endfunction

      function bit clip_side(longint p, longint q, inout longint n0, inout longint d0,
                             inout longint n1, inout longint d1);
         longint num, den;
         num = q;
         den = p;
         if (p == 0) return q >= 0;
         if (p < 0) begin
            num = -q;
            den = -p;
            if (num * d1 > n1 * den) return 0;
            if (num * d0 > n0 * den) begin
               n0 = num;
               d0 = den;
            end
         end else begin
            if (num * d0 < n0 * den) return 0;
            if (num * d1 < n1 * den) begin
               n1 = num;
               d1 = den;
            end
         end
         return 1;
      endfunction

      function longint clip_pt(longint o, longint n, longint d, longint delta);
         longint s, prod, q, rm;
         s    = 1 << CLIP_SHIFT;
         prod = n * delta;
         q    = fdiv(prod, d);
         rm   = prod - q * d;
         return o * s + q * s + (rm * s) / d;
      endfunction

      function bit draw(cmd_type c, longint a);
         longint wl, hl, dx, dy, n0, d0, n1, d1, x0, y0, x1, y1;
         longint ma0, mi0, ma1, mi1, t, dma, grad, s, e, pos, ip, f;
         logic [COL_W-1:0] rgb[3];
         bit ymaj;
         rgb[0] = c.red;
         rgb[1] = c.green;
         rgb[2] = c.blue;
         wl = (used_w() - 1) << COORD_FRAC_BITS;
         hl = (used_h() - 1) << COORD_FRAC_BITS;
         dx = longint'(c.ex) - longint'(c.sx);
         dy = longint'(c.ey) - longint'(c.sy);
         n0 = 0; d0 = 1; n1 = 1; d1 = 1;
         if (!clip_side(-dx, c.sx, n0, d0, n1, d1)) return 1;
         if (!clip_side(dx, wl - c.sx, n0, d0, n1, d1)) return 1;
         if (!clip_side(-dy, c.sy, n0, d0, n1, d1)) return 1;
         if (!clip_side(dy, hl - c.sy, n0, d0, n1, d1)) return 1;
         x0 = clip_pt(c.sx, n0, d0, dx);
         y0 = clip_pt(c.sy, n0, d0, dy);
         x1 = clip_pt(c.sx, n1, d1, dx);
         y1 = clip_pt(c.sy, n1, d1, dy);
         dx = x1 - x0;
         dy = y1 - y0;
         ymaj = ((dx < 0) ? -dx : dx) < ((dy < 0) ? -dy : dy);
         if (ymaj) begin
            ma0 = y0; mi0 = x0; ma1 = y1; mi1 = x1;
         end else begin
            ma0 = x0; mi0 = y0; ma1 = x1; mi1 = y1;
         end
         if (ma0 > ma1) begin
            t = ma0; ma0 = ma1; ma1 = t;
            t = mi0; mi0 = mi1; mi1 = t;
         end
         dma  = ma1 - ma0;
         grad = (dma == 0) ? 0 : fdiv((mi1 - mi0) * Q_ONE, dma);
         s    = (ma0 + Q_HALF) / Q_ONE;
         e    = (ma1 + Q_HALF) / Q_ONE;
         pos  = mi0 + fdiv(grad * (s * Q_ONE - ma0), Q_ONE);
         for (longint k = s; k <= e; k++) begin
            ip = fdiv(pos, Q_ONE);
            f  = pos - ip * Q_ONE;
            if (ymaj) begin
               blend(ip, k, rgb, a * (Q_ONE - f));
               blend(ip + 1, k, rgb, a * f);
            end else begin
               blend(k, ip, rgb, a * (Q_ONE - f));
               blend(k, ip + 1, rgb, a * f);
            end
            pos += grad;
         end
         return 0;
      endfunction

      function void note_cmd(cmd_type c);
         pixel_reply_type r;
         longint a, col, row;
         a = (c.alpha > FULL_ALPHA) ? FULL_ALPHA : c.alpha;
         r.colour   = '0;
         r.rejected = 0;
         case (c.func)
            FUNC_CLEAR: begin
               for (longint y = 0; y < used_h(); y++)
                  for (longint x = 0; x < used_w(); x++)
                     frame[y*MAX_WIDTH+x] = {c.red, c.green, c.blue};
            end
            FUNC_LINE: begin
               r.rejected = draw(c, a);
               lines++;
               if (r.rejected) rejects++;
            end
            FUNC_READ: begin
               col = fdiv(c.sx, 1 << COORD_FRAC_BITS);
               row = fdiv(c.sy, 1 << COORD_FRAC_BITS);
               if (col >= 0 && row >= 0 && col < used_w() && row < used_h())
                  r.colour = frame[row*MAX_WIDTH+col];
            end
            default: ;
         endcase
         replies.push_back(r);
      endfunction

      function void check_beat(logic [RSP_DATA_W-1:0] data, logic user);
         pixel_reply_type r;
         if (replies.size() == 0) begin
            $display("%0t: unexpected beat colour %h rejected %b", $time, data, user);
            errors++;
            return;
         end
         r = replies.pop_front();
         checked++;
         if (data !== r.colour) begin
            $display("%0t: pixel_colour expected %h actual %h", $time, r.colour, data);
            errors++;
         end
         if (user !== r.rejected) begin
            $display("%0t: line_rejected expected %b actual %b", $time, r.rejected, user);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_data = '0;

   frame_scoreboard sb = new();
   bit quiet = 0;
   longint fw = CFG_RESET, fh = CFG_RESET;

   antialiased_line_drawer dut (.*);

   always #4 clock = ~clock;

   task automatic send_cmd(cmd_type c);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser  = c.func;
      req_tdata  = {7'd0, c.alpha, c.blue, c.green, c.red, c.ey, c.ex, c.sy, c.sx};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_cmd(c);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      while (sb.replies.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data  = val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic cmd_type mk(logic [FUNC_W-1:0] f, int sx, int sy, int ex, int ey,
                                  logic [RGB_W-1:0] rgb, int a);
      cmd_type c;
      c.func = f;
      c.sx = CRD_W'(sx); c.sy = CRD_W'(sy); c.ex = CRD_W'(ex); c.ey = CRD_W'(ey);
      {c.red, c.green, c.blue} = rgb;
      c.alpha = ALPHA_W'(a);
      return c;
   endfunction

   function automatic int near_coord(longint lim);
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $urandom_range(0, (lim + 16) * 256) - 8 * 256;
   endfunction

   function automatic cmd_type rand_cmd(ref int clears_left);
      cmd_type c;
      int k;
      c = mk(FUNC_LINE, near_coord(fw), near_coord(fh), near_coord(fw), near_coord(fh),
             RGB_W'($urandom), $urandom_range(0, 511));
      k = $urandom_range(0, 99);
      if (k < 6) c.alpha = '0;
      else if (k < 30) c.alpha = ALPHA_W'(FULL_ALPHA);
      k = $urandom_range(0, 99);
      if (k < 4) c.func = FUNC_NONE;
      else if (k < 8 && clears_left > 0) begin
         c.func = FUNC_CLEAR;
         clears_left--;
      end else if (k < 45) begin
         c.func = FUNC_READ;
         if ($urandom_range(0, 5) != 0) begin
            c.sx = CRD_W'($urandom_range(0, fw * 256 - 1));
            c.sy = CRD_W'($urandom_range(0, fh * 256 - 1));
         end
      end
      return c;
   endfunction

   initial begin
      int clears;
      int widths[6]  = '{256, 1, 0, 17, 64, 511};
      int heights[6] = '{256, 1, 511, 9, 40, 3};
      int counts[6]  = '{100, 180, 160, 330, 260, 120};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
      send_cmd(mk(FUNC_READ, 0, 0, 0, 0, '0, 0));
      send_cmd(mk(FUNC_CLEAR, 0, 0, 0, 0, 24'h203040, 0));
      send_cmd(mk(FUNC_READ, 255*256, 255*256, 0, 0, '0, 0));
      send_cmd(mk(FUNC_LINE, 10*256+77, 20*256+3, 200*256+129, 20*256+200, 24'hff8000, 256));
      send_cmd(mk(FUNC_LINE, 30*256, 5*256+40, 31*256+99, 250*256, 24'h00ff7f, 130));
      send_cmd(mk(FUNC_LINE, 0, 0, 255*256, 255*256, 24'hffffff, 511));
      send_cmd(mk(FUNC_LINE, 40*256+128, 40*256+128, 40*256+128, 40*256+128, 24'h0000ff, 200));
      send_cmd(mk(FUNC_LINE, 5*256, 5*256, 90*256, 60*256, 24'hffffff, 0));
      send_cmd(mk(FUNC_LINE, -8388608, -8388608, 8388607, 8388607, 24'h123456, 100));
      send_cmd(mk(FUNC_LINE, -8388608, 100*256, 8388607, 120*256, 24'hfedcba, 256));
      send_cmd(mk(FUNC_LINE, -500*256, -10, -20*256, -300*256, 24'hffffff, 256));
      send_cmd(mk(FUNC_LINE, 300*256, 10*256, 400*256, 20*256, 24'hffffff, 256));
      send_cmd(mk(FUNC_LINE, 100*256, -8388608, 101*256, 8388607, 24'h00ffff, 77));
      send_cmd(mk(FUNC_READ, 40*256+200, 40*256+1, 0, 0, '0, 0));
      send_cmd(mk(FUNC_READ, 100*256, 60*256, 0, 0, '0, 0));
      send_cmd(mk(FUNC_READ, 20*256, 20*256, 0, 0, '0, 0));
      send_cmd(mk(FUNC_READ, -1, 8, 0, 0, '0, 0));
      send_cmd(mk(FUNC_READ, 8388607, 8388607, 0, 0, '0, 0));
      send_cmd(mk(FUNC_READ, -8388608, 3*256, 0, 0, '0, 0));
      send_cmd(mk(FUNC_NONE, -1, -1, -1, -1, 24'hffffff, 511));
      send_cmd(mk(FUNC_READ, 0, 0, 0, 0, '0, 0));
      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            write_reg(CSR_WIDTH, CFG_W'(widths[p]));
            write_reg(CSR_HEIGHT, CFG_W'(heights[p]));
            fw = sb.used_w();
            fh = sb.used_h();
         end
         clears = (fw * fh > 8192) ? 1 : 12;
         for (int i = 0; i < counts[p]; i++) begin
            if (p == 5 && i > counts[p] / 2) quiet = 1;
            send_cmd(rand_cmd(clears));
         end
      end
      while (sb.replies.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("checked %0d response beats, %0d lines (%0d rejected), over 6 frame sizes",
               sb.checked, sb.lines, sb.rejects);
      if (sb.errors == 0 && sb.replies.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (quiet) rsp_tready = 1;
         else if (stall > 0) begin
            rsp_tready = 0;
            stall--;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_tready = 0;
            stall = $urandom_range(0, 8);
         end else rsp_tready = 1;
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      #250ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
hdl/ald_pkg.sv
hdl/ald_div.sv
hdl/ald_front.sv
hdl/ald_back.sv
hdl/antialiased_line_drawer.sv
verif/antialiased_line_drawer_tb.sv
